### rtl/core/gnmc_pkg.sv
// Shared types and constants for the grid neighbor mine counter.
package gnmc_pkg;

  localparam int unsigned COL_W = 6;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned WIN_W = 9;
  localparam int unsigned CENTER_BIT = 4;

  localparam logic [WIN_W-1:0] KEEP_ALL  = 9'h1EF;
  localparam logic [WIN_W-1:0] TOP_ROW   = 9'h049;
  localparam logic [WIN_W-1:0] LEFT_COL  = 9'h007;
  localparam logic [WIN_W-1:0] RIGHT_COL = 9'h1C0;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_LATER  = 2'd3;

  typedef struct packed {
    logic emit;
    logic top_out;
    logic left_out;
    logic right_out;
    logic grid_done;
    logic last;
  } push_info_t;

endpackage

### rtl/core/gnmc_in_if.sv
// Input cell channel interface.
interface gnmc_in_if;
  logic valid;
  logic ready;
  logic mine;
  logic frame_end;

  modport source(output valid, output mine, output frame_end, input ready);
  modport sink(input valid, input mine, input frame_end, output ready);
endinterface

### rtl/core/gnmc_out_if.sv
// Result channel interface.
interface gnmc_out_if import gnmc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             is_mine;
  logic [CNT_W-1:0] mine_count;
  logic             row_end;
  logic             grid_done;
  logic             last_of_run;

  modport source(output valid, output is_mine, output mine_count, output row_end,
                 output grid_done, output last_of_run, input ready);
  modport sink(input valid, input is_mine, input mine_count, input row_end,
               input grid_done, input last_of_run, output ready);
endinterface

### rtl/core/gnmc_cell.sv
// One column slot of the two line stores.
module gnmc_cell import gnmc_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             shift,
  input  logic [COL_W-1:0] cols_m1,
  input  logic             mid_in,
  input  logic             up_in,
  input  logic             mid_next,
  input  logic             up_next,
  output logic             mid_q,
  output logic             up_q
);

  logic mid_r;
  logic up_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      mid_r <= 1'b0;
      up_r  <= 1'b0;
    end else if (shift) begin
      if (cols_m1 == COL_W'(IDX)) begin
        mid_r <= mid_in;
        up_r  <= up_in;
      end else begin
        mid_r <= mid_next;
        up_r  <= up_next;
      end
    end
  end

  assign mid_q = mid_r;
  assign up_q  = up_r;

endmodule

### rtl/core/gnmc_line.sv
// Chain of line cells; new bits enter at the last used column, taps at cell 0.
module gnmc_line import gnmc_pkg::*; #(
  parameter int unsigned DEPTH = 62
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             shift,
  input  logic [COL_W-1:0] cols_m1,
  input  logic             cell_bit,
  output logic             mid_tap,
  output logic             up_tap
);

  logic mid_q [DEPTH];
  logic up_q  [DEPTH];

  assign mid_tap = mid_q[0];
  assign up_tap  = up_q[0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic mid_nb;
    logic up_nb;
    if (k == DEPTH - 1) begin : g_end
      assign mid_nb = 1'b0;
      assign up_nb  = 1'b0;
    end else begin : g_mid
      assign mid_nb = mid_q[k+1];
      assign up_nb  = up_q[k+1];
    end
    gnmc_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (clear),
      .shift    (shift),
      .cols_m1  (cols_m1),
      .mid_in   (cell_bit),
      .up_in    (mid_tap),
      .mid_next (mid_nb),
      .up_next  (up_nb),
      .mid_q    (mid_q[k]),
      .up_q     (up_q[k])
    );
  end

endmodule

### rtl/core/gnmc_result.sv
// 3x3 window, neighbor count and output register.
module gnmc_result import gnmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [2:0]        colbits,
  input  push_info_t        info,
  output logic              s1_free,
  gnmc_out_if.source        out_ch
);

  logic [WIN_W-1:0] window_r;
  logic             s1_valid_r;
  push_info_t       s1_info_r;
  logic             out_valid_r;
  logic             is_mine_r;
  logic [CNT_W-1:0] count_r;
  logic             row_end_r;
  logic             done_r;
  logic             last_r;
  logic             adv;
  logic [WIN_W-1:0] keep;
  logic [WIN_W-1:0] bits;
  logic [CNT_W-1:0] cnt;

  assign adv     = !out_valid_r || out_ch.ready;
  assign s1_free = !s1_valid_r || adv;

  always_comb begin
    keep = KEEP_ALL;
    if (s1_info_r.top_out) keep = keep & ~TOP_ROW;
    if (s1_info_r.left_out) keep = keep & ~LEFT_COL;
    if (s1_info_r.right_out) keep = keep & ~RIGHT_COL;
    bits = window_r & keep;
    cnt = '0;
    for (int i = 0; i < WIN_W; i++) begin
      cnt = cnt + CNT_W'(bits[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      window_r <= {colbits, window_r[WIN_W-1:3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= push && info.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && push) begin
      s1_info_r <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      is_mine_r <= window_r[CENTER_BIT];
      count_r   <= window_r[CENTER_BIT] ? '0 : cnt;
      row_end_r <= s1_info_r.right_out;
      done_r    <= s1_info_r.grid_done;
      last_r    <= s1_info_r.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_mine     = is_mine_r;
  assign out_ch.mine_count  = count_r;
  assign out_ch.row_end     = row_end_r;
  assign out_ch.grid_done   = done_r;
  assign out_ch.last_of_run = last_r;

endmodule

### rtl/core/grid_neighbor_mine_count.sv
// Top level of the grid neighbor mine counter.
// Takes one grid cell per clock in raster order and returns, for each cell, its
// mine flag or the number of mines among its eight neighbors. A cell's result
// appears one grid row plus one cell of input later, plus two register stages.
// A transaction with frame_end set starts a flush that pushes columns+1 zero cells,
// during which in_ch.ready is low; otherwise one cell is taken every cycle,
// limited only by out_ch.ready. The line stores are a chain of flip-flop cells,
// all cleared together, so no clearing pass follows reset or a cfg write.
module grid_neighbor_mine_count import gnmc_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 62
) (
  input  logic             clk,
  input  logic             rst_n,
  gnmc_in_if.sink          in_ch,
  gnmc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [COL_W-1:0] cfg_data
);

  logic [COL_W-1:0] cols_r;
  logic [COL_W-1:0] cols_m1;
  logic [COL_W-1:0] pos_r;
  logic [1:0]       phase_r;
  logic             flushing_r;
  logic [COL_W-1:0] flush_left_r;
  logic             s1_free;
  logic             push;
  logic             cell_bit;
  logic             accept_fe;
  logic             final_push;
  logic             restart;
  logic             mid_tap;
  logic             up_tap;
  logic [COL_W-1:0] cols_nxt;
  push_info_t       info;

  assign cols_m1    = cols_r - COL_W'(1);
  assign push       = s1_free && (flushing_r || in_ch.valid);
  assign in_ch.ready = s1_free && !flushing_r;
  assign cell_bit   = flushing_r ? 1'b0 : in_ch.mine;
  assign accept_fe  = in_ch.valid && in_ch.ready && in_ch.frame_end;
  assign final_push = flushing_r && push && (flush_left_r == '0);
  assign restart    = cfg_we || final_push;

  always_comb begin
    info.emit      = (phase_r == PH_THIRD) || (phase_r == PH_LATER) ||
                     ((phase_r == PH_SECOND) && (pos_r != '0));
    info.top_out   = (phase_r == PH_SECOND) ||
                     ((phase_r == PH_THIRD) && (pos_r == '0));
    info.left_out  = (pos_r == COL_W'(1)) || ((pos_r == '0) && (cols_r == COL_W'(1)));
    info.right_out = (pos_r == '0);
    info.grid_done = final_push;
    info.last      = final_push || !(flushing_r || in_ch.frame_end);
  end

  always_comb begin
    if (cfg_data == '0) begin
      cols_nxt = COL_W'(1);
    end else if (cfg_data > COL_W'(MAX_COLUMNS)) begin
      cols_nxt = COL_W'(MAX_COLUMNS);
    end else begin
      cols_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COL_W'(MAX_COLUMNS);
    end else if (cfg_we) begin
      cols_r <= cols_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pos_r   <= '0;
      phase_r <= PH_FIRST;
    end else if (push) begin
      if (pos_r == cols_m1) begin
        pos_r   <= '0;
        phase_r <= (phase_r == PH_LATER) ? PH_LATER : phase_r + 2'd1;
      end else begin
        pos_r <= pos_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      flushing_r   <= 1'b0;
      flush_left_r <= '0;
    end else if (accept_fe) begin
      flushing_r   <= 1'b1;
      flush_left_r <= cols_r;
    end else if (flushing_r && push) begin
      if (flush_left_r == '0) begin
        flushing_r <= 1'b0;
      end else begin
        flush_left_r <= flush_left_r - COL_W'(1);
      end
    end
  end

  gnmc_line #(.DEPTH(MAX_COLUMNS)) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (restart),
    .shift    (push),
    .cols_m1  (cols_m1),
    .cell_bit (cell_bit),
    .mid_tap  (mid_tap),
    .up_tap   (up_tap)
  );

  gnmc_result u_result (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .colbits ({cell_bit, mid_tap, up_tap}),
    .info    (info),
    .s1_free (s1_free),
    .out_ch  (out_ch)
  );

endmodule

### sim/tb_top.sv
// Testbench for grid_neighbor_mine_count: directed and random raster grids checked against a neighbor-count predictor.
`timescale 1ns / 100ps

module tb_top;
  import gnmc_pkg::*;

  localparam int unsigned MAX_COLS   = 62;
  localparam int unsigned LONG_HOLD  = 200;
  localparam bit [8:0]    NO_CENTER  = 9'h1EF;
  localparam bit [8:0]    TOP_CELLS  = 9'h049;
  localparam bit [8:0]    LEFT_CELLS = 9'h007;
  localparam bit [8:0]    RIGHT_CELLS = 9'h1C0;

  typedef struct packed {
    bit mine;
    bit frame_end;
  } cell_item_t;

  typedef struct packed {
    bit             is_mine;
    bit [CNT_W-1:0] mine_count;
    bit             row_end;
    bit             grid_done;
    bit             last_of_run;
  } cell_report_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [COL_W-1:0] cfg_data;

  gnmc_in_if  in_ch();
  gnmc_out_if out_ch();

  grid_neighbor_mine_count #(.MAX_COLUMNS(MAX_COLS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  cell_item_t   cells_to_send[$];
  cell_report_t expected_reports[$];
  int unsigned  error_count;
  int unsigned  idle_pct;
  int unsigned  send_gap;
  int unsigned  recv_gap;
  int unsigned  hold_left;
  bit           hold_request;
  bit           cell_taken;

  // predictor state
  bit           upper_row[MAX_COLS];
  bit           middle_row[MAX_COLS];
  bit [8:0]     win;
  int unsigned  col_at;
  logic [1:0]   phase_at;
  int unsigned  grid_cols;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void clear_frame();
    for (int unsigned i = 0; i < MAX_COLS; i++) begin
      upper_row[i]  = 1'b0;
      middle_row[i] = 1'b0;
    end
    win      = '0;
    col_at   = 0;
    phase_at = PH_FIRST;
  endfunction

  function automatic void set_columns(bit [COL_W-1:0] value);
    if (value < 1) grid_cols = 1;
    else if (value > MAX_COLS) grid_cols = MAX_COLS;
    else grid_cols = value;
    clear_frame();
  endfunction

  function automatic void shift_cell(bit cell_val, ref cell_report_t run[$]);
    int unsigned  c;
    int unsigned  ctr;
    int unsigned  cnt;
    logic [1:0]   p;
    bit           top;
    bit           mid;
    bit [8:0]     keep;
    cell_report_t r;
    c = col_at;
    p = phase_at;
    if (c >= grid_cols) c = 0;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c]  = mid;
    middle_row[c] = cell_val;
    win = {cell_val, mid, top, win[8:3]};
    if (p >= PH_THIRD || (p == PH_SECOND && c >= 1)) begin
      ctr  = (c == 0) ? grid_cols - 1 : c - 1;
      keep = NO_CENTER;
      if (p == PH_SECOND || (p == PH_THIRD && c == 0)) keep &= ~TOP_CELLS;
      if (ctr == 0) keep &= ~LEFT_CELLS;
      if (ctr + 1 >= grid_cols) keep &= ~RIGHT_CELLS;
      cnt = $countones(win & keep);
      r.is_mine     = win[CENTER_BIT];
      r.mine_count  = win[CENTER_BIT] ? '0 : CNT_W'(cnt);
      r.row_end     = (ctr + 1 >= grid_cols);
      r.grid_done   = 1'b0;
      r.last_of_run = 1'b0;
      run.push_back(r);
    end
    if (c + 1 >= grid_cols) begin
      col_at = 0;
      if (p != PH_LATER) phase_at = p + 2'd1;
    end else begin
      col_at = c + 1;
    end
  endfunction

  function automatic void predict_neighbor_counts(bit mine, bit frame_end);
    cell_report_t run[$];
    shift_cell(mine, run);
    if (frame_end) begin
      for (int unsigned i = 0; i <= grid_cols; i++) shift_cell(1'b0, run);
      if (run.size() > 0) run[run.size()-1].grid_done = 1'b1;
      clear_frame();
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) expected_reports.push_back(run[i]);
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // transaction accept on the cell channel
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_neighbor_counts(in_ch.mine, in_ch.frame_end);
      cell_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    cell_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || cell_taken) begin
      cell_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (cells_to_send.size() > 0) begin
        nxt = cells_to_send.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.mine      <= nxt.mine;
        in_ch.frame_end <= nxt.frame_end;
        if ($urandom_range(99) < idle_pct) send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(99) < idle_pct) recv_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    cell_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result transaction: is_mine %0d mine_count %0d",
               out_ch.is_mine, out_ch.mine_count);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("is_mine", want.is_mine, out_ch.is_mine);
        check_field("mine_count", want.mine_count, out_ch.mine_count);
        check_field("row_end", want.row_end, out_ch.row_end);
        check_field("grid_done", want.grid_done, out_ch.grid_done);
        check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (cells_to_send.size() != 0 || in_ch.valid || expected_reports.size() != 0);
    repeat (grid_cols + 8) @(posedge clk);
  endtask

  task automatic write_columns(bit [COL_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    set_columns(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cell(bit mine, bit frame_end);
    cell_item_t it;
    it.mine      = mine;
    it.frame_end = frame_end;
    cells_to_send.push_back(it);
  endtask

  task automatic queue_frame(int unsigned len, bit closed, int unsigned density);
    for (int unsigned k = 0; k < len; k++)
      queue_cell($urandom_range(99) < density, closed && (k == len - 1));
  endtask

  initial begin
    int unsigned random_cells;
    int unsigned cols_val;
    int unsigned eff;
    int unsigned rows;
    int unsigned len;
    int unsigned frames;
    bit          first_phase;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.mine      = 1'b0;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    error_count     = 0;
    send_gap        = 0;
    recv_gap        = 0;
    hold_left       = 0;
    hold_request    = 1'b0;
    cell_taken      = 1'b0;
    idle_pct        = 25;
    grid_cols       = MAX_COLS;
    clear_frame();
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // first cell ends the frame, reset width
    queue_cell(1'b1, 1'b1);
    // single column, width 0 clamps to 1
    write_columns(6'd0);
    queue_cell(1'b1, 1'b0);
    queue_cell(1'b0, 1'b0);
    queue_cell(1'b1, 1'b1);
    queue_cell(1'b0, 1'b1);
    // ring of mines around an empty center
    write_columns(6'd3);
    for (int unsigned k = 0; k < 9; k++) queue_cell(k != 4, k == 8);
    // width 63 clamps to 62; frame dropped by the next write
    write_columns(6'd63);
    queue_cell(1'b1, 1'b0);
    queue_cell(1'b0, 1'b0);
    write_columns(6'd2);
    queue_cell(1'b1, 1'b0);
    queue_cell(1'b0, 1'b1);
    // frame end in the middle of a row
    queue_cell(1'b0, 1'b0);
    queue_cell(1'b1, 1'b0);
    queue_cell(1'b1, 1'b1);

    random_cells = 0;
    first_phase  = 1'b1;
    while (random_cells < 300) begin
      case ($urandom_range(9))
        0:       cols_val = $urandom_range(62, 63);
        1:       cols_val = $urandom_range(0, 1);
        default: cols_val = $urandom_range(2, 12);
      endcase
      write_columns(COL_W'(cols_val));
      eff = grid_cols;
      case ($urandom_range(3))
        0: idle_pct = 0;
        1: idle_pct = 15;
        2: idle_pct = 40;
        default: idle_pct = 70;
      endcase
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        rows = (eff >= 30) ? $urandom_range(1, 2) : $urandom_range(1, 5);
        len  = rows * eff;
        if ($urandom_range(3) == 0) len = $urandom_range(1, len);
        if (random_cells + len > 310) len = 310 - random_cells;
        if (len == 0) break;
        queue_frame(len, $urandom_range(9) != 0, $urandom_range(0, 100));
        random_cells += len;
      end
      if (first_phase || $urandom_range(3) == 0) hold_request = 1'b1;
      first_phase = 1'b0;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/core/gnmc_pkg.sv
rtl/core/gnmc_in_if.sv
rtl/core/gnmc_out_if.sv
rtl/core/gnmc_cell.sv
rtl/core/gnmc_line.sv
rtl/core/gnmc_result.sv
rtl/core/grid_neighbor_mine_count.sv
sim/tb_top.sv
